// File: rtl/core/tqls_pkg.sv
// Shared types, constants and pointer helpers for the two-queue lottery scheduler.
package tqls_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 16;

    localparam int FIELD_ID_W = 16;
    localparam int STORE_W    = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    localparam int RUN_W    = 16;
    localparam int CHANCE_W = 7;
    localparam int THR_W    = 16;
    localparam int SHARE_W  = 7;
    localparam int CFG_W    = 16;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(300);
    localparam logic [SHARE_W-1:0] SHARE_RESET     = SHARE_W'(70);

    typedef enum logic [2:0] {
        ROUTE_NONE     = 3'd0,
        ROUTE_FIRST    = 3'd1,
        ROUTE_SECOND   = 3'd2,
        ROUTE_BLOCKED  = 3'd3,
        ROUTE_FINISHED = 3'd4,
        ROUTE_BAD      = 3'd5,
        ROUTE_DROPPED  = 3'd6
    } t_route;

    typedef enum logic [1:0] {
        EXIT_READY    = 2'd0,
        EXIT_BLOCKED  = 2'd1,
        EXIT_FINISHED = 2'd2,
        EXIT_INVALID  = 2'd3
    } t_exit;

    typedef enum logic {
        CMD_SCHEDULE = 1'b0,
        CMD_ADMIT    = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_SHARE     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
    } t_qstate;

    typedef struct packed {
        t_cmd                cmd;
        logic                has_process;
        logic [STORE_W-1:0]  proc_id;
        logic [RUN_W-1:0]    run_time;
        t_exit               exit_state;
        logic [CHANCE_W-1:0] chance;
    } t_request;

    typedef struct packed {
        t_route           route;
        logic             push_first;
        logic             push_second;
        logic [PTR_W-1:0] wr_addr;
        logic             sel_valid;
        logic             sel_queue;
        logic             fell;
        logic             fwd;
        logic [PTR_W-1:0] rd_addr;
        t_qstate          first_next;
        t_qstate          second_next;
    } t_decision;

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] tail_ptr(t_qstate q);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(q.head) + SUM_W'(q.count);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// File: rtl/core/tqls_ram.sv
// Generic simple dual-port RAM with registered read.
module tqls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tqls_decide.sv
// Routing and queue draw decision for one request, plus next queue pointers.
module tqls_decide (
    input  tqls_pkg::t_request                 i_req,
    input  logic [tqls_pkg::THR_W-1:0]         i_threshold,
    input  logic [tqls_pkg::SHARE_W-1:0]       i_share,
    input  tqls_pkg::t_qstate                  i_first,
    input  tqls_pkg::t_qstate                  i_second,
    output tqls_pkg::t_decision                o_dec
);
    import tqls_pkg::*;

    logic       to_first;
    logic       target_full;
    logic       target_empty;
    logic       push_ok;
    logic       draw_first;
    logic       use_first;
    t_qstate    first_p;
    t_qstate    second_p;

    assign to_first     = i_req.run_time > i_threshold;
    assign target_full  = to_first ? (i_first.count == CNT_W'(QUEUE_DEPTH))
                                   : (i_second.count == CNT_W'(QUEUE_DEPTH));
    assign target_empty = to_first ? (i_first.count == '0) : (i_second.count == '0);
    assign draw_first   = i_req.chance < i_share;

    always_comb begin
        o_dec          = '0;
        o_dec.route    = ROUTE_NONE;
        push_ok        = 1'b0;
        first_p        = i_first;
        second_p       = i_second;
        use_first      = 1'b0;

        // enqueue side
        if (i_req.has_process) begin
            case (i_req.exit_state)
                EXIT_READY: begin
                    if (target_full) begin
                        o_dec.route = ROUTE_DROPPED;
                    end else begin
                        push_ok = 1'b1;
                        o_dec.route = to_first ? ROUTE_FIRST : ROUTE_SECOND;
                    end
                end
                EXIT_BLOCKED:  o_dec.route = ROUTE_BLOCKED;
                EXIT_FINISHED: o_dec.route = ROUTE_FINISHED;
                default:       o_dec.route = ROUTE_BAD;
            endcase
        end

        o_dec.wr_addr     = to_first ? tail_ptr(i_first) : tail_ptr(i_second);
        o_dec.push_first  = push_ok & to_first;
        o_dec.push_second = push_ok & ~to_first;
        if (o_dec.push_first) begin
            first_p.count = i_first.count + CNT_W'(1);
        end
        if (o_dec.push_second) begin
            second_p.count = i_second.count + CNT_W'(1);
        end

        // draw side, sees the queues after this request's push
        if (i_req.cmd == CMD_SCHEDULE && (first_p.count != '0 || second_p.count != '0)) begin
            if (draw_first) begin
                use_first  = first_p.count != '0;
                o_dec.fell = ~use_first;
            end else begin
                use_first  = second_p.count == '0;
                o_dec.fell = use_first;
            end
            o_dec.sel_valid = 1'b1;
            o_dec.sel_queue = ~use_first;
            // freshly pushed id into an empty queue is not in the RAM read path yet
            o_dec.fwd       = push_ok && (to_first == use_first) && target_empty;
            if (use_first) begin
                o_dec.rd_addr  = first_p.head;
                first_p.head   = next_ptr(first_p.head);
                first_p.count  = first_p.count - CNT_W'(1);
            end else begin
                o_dec.rd_addr  = second_p.head;
                second_p.head  = next_ptr(second_p.head);
                second_p.count = second_p.count - CNT_W'(1);
            end
        end

        o_dec.first_next  = first_p;
        o_dec.second_next = second_p;
    end

endmodule

// File: rtl/core/two_queue_lottery_scheduler.sv
// Top level of the two-queue lottery scheduler: request intake, queue RAMs, result register.
// A request is accepted in S_IDLE or S_OUT, its queue RAM read runs in S_READ, and its
// result is registered into the output on leaving S_READ; a new request is taken only
// while idle or as the previous result is being taken by the receiver.
// Reset: synchronous, active low; both queues empty, threshold 300, share 70.
//   Queue RAM contents are not cleared; only occupied entries ever reach a result.
module two_queue_lottery_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [tqls_pkg::CFG_W-1:0]     i_cfg_data,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // proc_id[15:0], run_time_total[31:16], exit_state[33:32], chance[40:34], zero pad
    input  logic [tqls_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command[0], has_process[1]
    input  logic [tqls_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // routed_to[2:0], selected_valid[3], selected_id[19:4], selected_queue[20],
    // fell_back[21], zero pad
    output logic [tqls_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import tqls_pkg::*;

    // IDLE: waiting for a request; READ: RAM read in flight; OUT: result held
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    t_state              r_state;
    logic                r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    logic [THR_W-1:0]    r_threshold;
    logic [SHARE_W-1:0]  r_share;
    t_qstate             r_first;
    t_qstate             r_second;

    // per-request bits carried across the RAM read
    t_route              r_route;
    logic                r_sel_valid;
    logic                r_sel_queue;
    logic                r_fell;
    logic                r_fwd;
    logic [STORE_W-1:0]  r_fwd_id;

    t_request            req;
    t_decision           decision;
    logic                accept;
    logic [STORE_W-1:0]  first_rdata;
    logic [STORE_W-1:0]  second_rdata;
    logic [STORE_W-1:0]  sel_id;

    assign req.cmd         = t_cmd'(s_axis_tuser[0]);
    assign req.has_process = s_axis_tuser[1];
    assign req.proc_id     = s_axis_tdata[STORE_W-1:0];   // ids kept at ID_WIDTH bits
    assign req.run_time    = s_axis_tdata[31:16];
    assign req.exit_state  = t_exit'(s_axis_tdata[33:32]);
    assign req.chance      = s_axis_tdata[40:34];

    // next request may enter while idle or as the held result leaves
    assign s_axis_tready = (r_state == S_IDLE) || (r_state == S_OUT && m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    tqls_decide u_decide (
        .i_req       (req),
        .i_threshold (r_threshold),
        .i_share     (r_share),
        .i_first     (r_first),
        .i_second    (r_second),
        .o_dec       (decision)
    );

    // Push and pop land on different entries unless the queue was empty;
    // that case is covered by forwarding the pushed id.
    tqls_ram #(
        .WIDTH (STORE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (accept && decision.push_first),
        .i_waddr (decision.wr_addr),
        .i_wdata (req.proc_id),
        .i_raddr (decision.rd_addr),
        .o_rdata (first_rdata)
    );

    tqls_ram #(
        .WIDTH (STORE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (accept && decision.push_second),
        .i_waddr (decision.wr_addr),
        .i_wdata (req.proc_id),
        .i_raddr (decision.rd_addr),
        .o_rdata (second_rdata)
    );

    always_comb begin
        if (!r_sel_valid) begin
            sel_id = '0;
        end else if (r_fwd) begin
            sel_id = r_fwd_id;
        end else if (r_sel_queue) begin
            sel_id = second_rdata;
        end else begin
            sel_id = first_rdata;
        end
    end

    // control state, result register, queue pointers, config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m_tvalid  <= 1'b0;
            r_m_tdata   <= '0;
            r_threshold <= THRESHOLD_RESET;
            r_share     <= SHARE_RESET;
            r_first     <= '0;
            r_second    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // RAM data is in; pack the result
                    r_state    <= S_OUT;
                    r_m_tvalid <= 1'b1;
                    r_m_tdata  <= {2'b00, r_fell, r_sel_queue, FIELD_ID_W'(sel_id),
                                   r_sel_valid, r_route};
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_m_tvalid <= 1'b0;
                        r_state    <= accept ? S_READ : S_IDLE;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_m_tvalid <= 1'b0;
                end
            endcase

            if (accept) begin
                r_first  <= decision.first_next;
                r_second <= decision.second_next;
            end

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    CFG_SHARE:     r_share     <= i_cfg_data[SHARE_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // payload: decision bits captured at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_route     <= decision.route;
            r_sel_valid <= decision.sel_valid;
            r_sel_queue <= decision.sel_queue;
            r_fell      <= decision.fell;
            r_fwd       <= decision.fwd;
            r_fwd_id    <= req.proc_id;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

// File: tb/sv/tb_two_queue_lottery_scheduler.sv
// Self-checking testbench for the two-queue lottery scheduler: directed table, then random phases.
module tb_two_queue_lottery_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import tqls_pkg::*;

    // Cycles with no request or result moving before the run is declared hung.
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int PHASE_COUNT      = 8;
    localparam int ITEMS_PER_PHASE  = 175;
    // Extra wait after the last decision comes back, so the block is quiet before moving on.
    localparam int DRAIN_CYCLES     = 8;

    // One scheduler request as the block sees it.
    typedef struct {
        t_cmd        cmd;
        logic        has_proc;
        logic [15:0] proc_id;
        logic [15:0] run_time;
        t_exit       exit_st;
        logic [6:0]  chance;
    } t_sched_req;

    // One scheduler decision.
    typedef struct {
        t_route      route;
        logic        sel_valid;
        logic [15:0] sel_id;
        logic        sel_queue;
        logic        fell;
    } t_sched_res;

    // Directed row: a request plus, where it is obvious, the decision typed in.
    typedef struct {
        t_sched_req req;
        logic       typed;
        t_sched_res res;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Predictor state: our own view of both ready queues and the registers.
    logic [15:0]        long_queue_ids[$];
    logic [15:0]        short_queue_ids[$];
    logic [THR_W-1:0]   long_job_thr;
    logic [SHARE_W-1:0] long_share;

    t_sched_res pending_decisions[$];
    t_dir_row   directed_rows[$];

    int error_count;
    int sender_idle_pct;
    int receiver_stall_pct;

    two_queue_lottery_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Decision for one request; updates the predicted queues on the way.
    function automatic t_sched_res predict_decision(t_sched_req r);
        t_sched_res res;
        logic       to_long;
        logic       draw_long;
        logic       take_long;
        res.route     = ROUTE_NONE;
        res.sel_valid = 1'b0;
        res.sel_id    = '0;
        res.sel_queue = 1'b0;
        res.fell      = 1'b0;
        if (r.has_proc) begin
            case (r.exit_st)
                EXIT_READY: begin
                    to_long = r.run_time > long_job_thr;
                    if (to_long && long_queue_ids.size() < QUEUE_DEPTH) begin
                        long_queue_ids.push_back(r.proc_id);
                        res.route = ROUTE_FIRST;
                    end else if (!to_long && short_queue_ids.size() < QUEUE_DEPTH) begin
                        short_queue_ids.push_back(r.proc_id);
                        res.route = ROUTE_SECOND;
                    end else begin
                        res.route = ROUTE_DROPPED;
                    end
                end
                EXIT_BLOCKED:  res.route = ROUTE_BLOCKED;
                EXIT_FINISHED: res.route = ROUTE_FINISHED;
                default:       res.route = ROUTE_BAD;
            endcase
        end
        // Selection sees the queues after this request's own enqueue.
        if (r.cmd == CMD_SCHEDULE &&
            (long_queue_ids.size() != 0 || short_queue_ids.size() != 0)) begin
            draw_long = r.chance < long_share;
            if (draw_long) begin
                take_long = long_queue_ids.size() != 0;
                res.fell  = !take_long;
            end else begin
                take_long = short_queue_ids.size() == 0;
                res.fell  = take_long;
            end
            res.sel_id    = take_long ? long_queue_ids.pop_front()
                                      : short_queue_ids.pop_front();
            res.sel_queue = !take_long;
            res.sel_valid = 1'b1;
        end
        return res;
    endfunction

    // Offer one request, wait for the handshake, record the expected decision,
    // then maybe leave a random gap before the next one.
    task automatic send_request(input t_sched_req r, input logic typed, input t_sched_res res);
        t_sched_res predicted;
        int         gap;
        s_axis_tdata  <= {7'b0, r.chance, r.exit_st, r.run_time, r.proc_id};
        s_axis_tuser  <= {r.has_proc, r.cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = predict_decision(r);
        pending_decisions.push_back(typed ? res : predicted);
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_cmd cmd, input logic has_proc, input logic [15:0] id,
                           input logic [15:0] run, input t_exit ex, input logic [6:0] chance,
                           input logic typed, input t_route route);
        t_dir_row row;
        row.req.cmd       = cmd;
        row.req.has_proc  = has_proc;
        row.req.proc_id   = id;
        row.req.run_time  = run;
        row.req.exit_st   = ex;
        row.req.chance    = chance;
        row.typed         = typed;
        row.res.route     = route;
        row.res.sel_valid = 1'b0;
        row.res.sel_id    = '0;
        row.res.sel_queue = 1'b0;
        row.res.fell      = 1'b0;
        directed_rows.push_back(row);
    endtask

    // Run time on the wanted side of the current threshold most of the time, with picks right at
    // the edge so both sides of the strict compare get hit; the rest spans the whole field.
    function automatic logic [15:0] pick_run_time(logic want_long);
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) return 16'($urandom);
        if (want_long) begin
            if (long_job_thr == 16'hFFFF) return 16'hFFFF;
            if (pick == 1) return long_job_thr + 16'd1;
            if (pick == 2) return 16'hFFFF;
            return 16'($urandom_range(int'(long_job_thr) + 1, 65535));
        end
        if (pick == 1) return long_job_thr;
        if (pick == 2) return 16'd0;
        return 16'($urandom_range(0, int'(long_job_thr)));
    endfunction

    function automatic logic [6:0] pick_chance();
        if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, 99));
    endfunction

    // Burst kinds: fill queues with admits, drain with schedules, well-formed
    // mix, or raw noise over every field.
    function automatic t_sched_req random_request(int kind, logic fill_long);
        t_sched_req r;
        r.proc_id  = 16'($urandom);
        r.chance   = pick_chance();
        r.exit_st  = EXIT_READY;
        r.has_proc = 1'b1;
        case (kind)
            0: begin
                r.cmd      = ($urandom_range(0, 7) == 0) ? CMD_SCHEDULE : CMD_ADMIT;
                r.run_time = pick_run_time(fill_long);
            end
            1: begin
                r.cmd      = ($urandom_range(0, 7) == 0) ? CMD_ADMIT : CMD_SCHEDULE;
                r.has_proc = ($urandom_range(0, 3) == 0);
                r.exit_st  = t_exit'($urandom_range(0, 3));
                r.run_time = pick_run_time(1'($urandom_range(0, 1)));
            end
            2: begin
                r.cmd      = t_cmd'($urandom_range(0, 1));
                r.has_proc = ($urandom_range(0, 4) != 0);
                r.exit_st  = ($urandom_range(0, 2) != 0) ? EXIT_READY
                                                         : t_exit'($urandom_range(1, 3));
                r.run_time = pick_run_time(1'($urandom_range(0, 1)));
            end
            default: begin
                r.cmd      = t_cmd'($urandom_range(0, 1));
                r.has_proc = 1'($urandom_range(0, 1));
                r.exit_st  = t_exit'($urandom_range(0, 3));
                r.run_time = 16'($urandom);
                r.chance   = 7'($urandom_range(0, 127));
            end
        endcase
        return r;
    endfunction

    // Wait for every decision to come back, let the pipeline settle, then
    // write both registers; the write data above bit 6 is junk for the share.
    task automatic write_registers(input logic [15:0] thr, input logic [15:0] share_data);
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_index <= CFG_SHARE;
        i_cfg_data  <= share_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        long_job_thr = thr;
        long_share   = share_data[SHARE_W-1:0];
    endtask

    // Stimulus: reset, directed table, then random phases over several settings.
    initial begin
        t_sched_req r;
        t_sched_res none_res;
        logic [15:0] thr_set [PHASE_COUNT];
        logic [15:0] share_set [PHASE_COUNT];
        int          sent;
        int          kind;
        int          burst;
        logic        fill_long;

        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        long_job_thr       = THRESHOLD_RESET;
        long_share         = SHARE_RESET;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_THRESHOLD;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under reset settings (threshold 300, share 70).
        // Empty queues after reset: nothing selected.
        add_row(CMD_SCHEDULE, 0, 16'h0000, 16'd0, EXIT_READY, 7'd0, 1, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 0, 16'hFFFF, 16'hFFFF, EXIT_INVALID, 7'd127, 1, ROUTE_NONE);
        // Non-ready exit states are only reported.
        add_row(CMD_ADMIT, 1, 16'hFFFF, 16'hFFFF, EXIT_BLOCKED, 7'd127, 1, ROUTE_BLOCKED);
        add_row(CMD_ADMIT, 1, 16'h0000, 16'd0, EXIT_FINISHED, 7'd0, 1, ROUTE_FINISHED);
        add_row(CMD_ADMIT, 1, 16'h1234, 16'd300, EXIT_INVALID, 7'd50, 1, ROUTE_BAD);
        add_row(CMD_SCHEDULE, 1, 16'h4321, 16'd301, EXIT_INVALID, 7'd0, 1, ROUTE_BAD);
        // Threshold compare is strict: 301 goes long, 300 goes short.
        add_row(CMD_ADMIT, 1, 16'hFFFF, 16'd301, EXIT_READY, 7'd99, 1, ROUTE_FIRST);
        add_row(CMD_ADMIT, 1, 16'h0000, 16'd300, EXIT_READY, 7'd0, 1, ROUTE_SECOND);
        add_row(CMD_ADMIT, 1, 16'h5A5A, 16'hFFFF, EXIT_READY, 7'd10, 0, ROUTE_NONE);
        // Draw edges around the share, then fallback from the short side.
        add_row(CMD_SCHEDULE, 0, 16'h0000, 16'd0, EXIT_READY, 7'd69, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 0, 16'h0000, 16'd0, EXIT_READY, 7'd70, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 0, 16'h0000, 16'd0, EXIT_READY, 7'd127, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 0, 16'h0000, 16'd0, EXIT_READY, 7'd0, 0, ROUTE_NONE);
        // Fallback from the long side.
        add_row(CMD_ADMIT, 1, 16'hA5A5, 16'd0, EXIT_READY, 7'd0, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 0, 16'h0000, 16'd0, EXIT_READY, 7'd0, 0, ROUTE_NONE);
        // Enqueued and picked in the same request, then non-ready exits scheduled on empty queues.
        add_row(CMD_SCHEDULE, 1, 16'h0F0F, 16'd1000, EXIT_READY, 7'd0, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 1, 16'hF0F0, 16'd0, EXIT_READY, 7'd127, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 1, 16'h7777, 16'd500, EXIT_BLOCKED, 7'd50, 0, ROUTE_NONE);
        add_row(CMD_SCHEDULE, 1, 16'h8888, 16'd5, EXIT_FINISHED, 7'd99, 0, ROUTE_NONE);
        // Admit without a process does nothing at all.
        add_row(CMD_ADMIT, 0, 16'hFFFF, 16'hFFFF, EXIT_READY, 7'd0, 1, ROUTE_NONE);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        s_axis_tvalid <= 1'b0;

        thr_set   = '{16'd300, 16'd0, 16'hFFFF, 16'd1000, 16'd12345, 16'($urandom),
                      16'd1, 16'($urandom)};
        share_set = '{16'd70, 16'd0, 16'd100, 16'hFFFF,
                      {9'($urandom), 7'd50}, 16'($urandom),
                      16'd1, {9'($urandom), 7'($urandom_range(0, 127))}};
        none_res.route     = ROUTE_NONE;
        none_res.sel_valid = 1'b0;
        none_res.sel_id    = '0;
        none_res.sel_queue = 1'b0;
        none_res.fell      = 1'b0;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_registers(thr_set[p], share_set[p]);
            // Idling pattern cycles: none, sender gaps, receiver stalls, both light.
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                kind      = $urandom_range(0, 9);
                kind      = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind < 9) ? 2 : 3;
                burst     = (kind == 0) ? $urandom_range(8, 20) : $urandom_range(4, 24);
                fill_long = 1'($urandom_range(0, 1));
                for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
                    r = random_request(kind, fill_long);
                    send_request(r, 1'b0, none_res);
                    sent++;
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_two_queue_lottery_scheduler passed");
        end else begin
            $display("tb_two_queue_lottery_scheduler failed");
        end
        $finish;
    end

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Result side: compare each accepted decision with the oldest expectation,
    // and drive a randomly stalling tready.
    initial begin
        t_sched_res exp_res;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_decisions.size() == 0) begin
                    $display("%0t: unexpected decision, expected none actual %0h",
                             $time, m_axis_tdata);
                    error_count++;
                end else begin
                    exp_res = pending_decisions.pop_front();
                    check_field("routed_to", 16'(exp_res.route), 16'(m_axis_tdata[2:0]));
                    check_field("selected_valid", 16'(exp_res.sel_valid),
                                16'(m_axis_tdata[3]));
                    check_field("selected_id", exp_res.sel_id, m_axis_tdata[19:4]);
                    check_field("selected_queue", 16'(exp_res.sel_queue),
                                16'(m_axis_tdata[20]));
                    check_field("fell_back", 16'(exp_res.fell), 16'(m_axis_tdata[21]));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Hang detection: any request or decision moving resets the count.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("tb_two_queue_lottery_scheduler failed");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
rtl/core/tqls_pkg.sv
rtl/core/tqls_ram.sv
rtl/core/tqls_decide.sv
rtl/core/two_queue_lottery_scheduler.sv
tb/sv/tb_two_queue_lottery_scheduler.sv
